[src/pptb_pkg.sv]
package pptb_pkg;

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_RETIME = 3'd3;
  localparam logic [2:0] FUNC_RUN    = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  // Acknowledge status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_ABSENT  = 2'd2;

  // Main period value that disables the main period check.
  localparam logic [31:0] NO_MAIN_PERIOD = 32'hFFFF_FFFF;

  // Slot numbers the slot field can address.
  localparam int unsigned SLOT_FIELD_SLOTS = 16;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic [2:0]  prio;
    logic [31:0] now_ms;
    logic        run;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       main_due;
    logic [1:0] status;
    logic       last;
  } out_t;

endpackage

[src/priority_periodic_timer_bank.sv]
// Tick: an accept step, a check of each listed slot in list order, then a finish beat;
// the walk is held only while the output register is held by out_stall_i.
// Add: accept, a list scan for the insertion point, a list shift, an acknowledge.
// Remove: accept, a scan for the slot, a shift and an acknowledge. Retime, run, refused
// requests and unknown codes go from accept straight to the acknowledge.
// One item is in flight at a time; the shared subtract, compare and add unit sets the pace.
// Reset clears the present flags, list count and main start, and arms the first tick.
module priority_periodic_timer_bank #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pptb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pptb_pkg::out_t  out_data_o
);

  // Only slots that the slot field can name are ever stored.
  localparam int unsigned NS = (NUM_SLOTS < pptb_pkg::SLOT_FIELD_SLOTS) ?
                               NUM_SLOTS : pptb_pkg::SLOT_FIELD_SLOTS;
  localparam int unsigned SW = $clog2(NS);
  localparam int unsigned CW = $clog2(NS + 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_TICK      = 3'd1;
  localparam logic [2:0] S_INS_SCAN  = 3'd2;
  localparam logic [2:0] S_INS_SHIFT = 3'd3;
  localparam logic [2:0] S_DEL_SCAN  = 3'd4;
  localparam logic [2:0] S_DEL_SHIFT = 3'd5;
  localparam logic [2:0] S_ACK       = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            first_q, first_d;
  logic [31:0]     main_start_q, main_start_d;
  logic [1:0]      status_q, status_d;
  pptb_pkg::in_t   item_q;
  logic            out_vld_q, out_vld_d;
  pptb_pkg::out_t  out_q, out_d;

  // Per-slot storage.
  logic [NS-1:0]   present_q;
  logic [NS-1:0]   running_q;
  logic [31:0]     period_q [NS];
  logic [31:0]     start_q  [NS];
  logic [2:0]      prio_q   [NS];
  logic [SW-1:0]   order_q  [NS];

  logic            accept;
  logic            out_free;
  logic            in_range;
  logic [SW-1:0]   in_idx;
  logic            in_present;
  logic [SW-1:0]   item_idx;
  logic            pos_in_list;
  logic [SW-1:0]   cur;

  // Shared arithmetic unit operands and results.
  logic [31:0]     base_sel;
  logic [31:0]     lim_sel;
  logic [31:0]     diff;
  logic            reached;
  logic [31:0]     advanced;

  // Storage write controls.
  logic            add_we;
  logic            start_we;
  logic [31:0]     start_val;
  logic            retime_we;
  logic            run_we;
  logic            ins_we;
  logic            del_we;
  logic            load_item;
  logic            ins_before;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;

  // Slot decode of the incoming beat and of the held item.
  assign in_range   = ({1'b0, in_data_i.slot} < 5'(NS));
  assign in_idx     = in_data_i.slot[SW-1:0];
  assign in_present = in_range && present_q[in_idx];
  assign item_idx   = item_q.slot[SW-1:0];

  // Walk position within the list and the slot found there.
  assign pos_in_list = (pos_q < cnt_q);
  assign cur         = order_q[pos_q[SW-1:0]];

  // One subtract, compare and add unit, shared by slot checks and the main period check.
  always_comb begin
    if (state_q == S_TICK && pos_in_list) begin
      base_sel = start_q[cur];
      lim_sel  = period_q[cur];
    end else begin
      base_sel = main_start_q;
      lim_sel  = item_q.period_ms;
    end
    diff     = item_q.now_ms - base_sel;
    reached  = (diff >= lim_sel);
    advanced = base_sel + lim_sel;
  end

  // Insertion order: higher priority first, then equal or shorter period first.
  assign ins_before = (prio_q[item_idx] > prio_q[cur]) ||
                      ((prio_q[item_idx] == prio_q[cur]) &&
                       (period_q[item_idx] <= period_q[cur]));

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    first_d      = first_q;
    main_start_d = main_start_q;
    status_d     = status_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_d        = out_q;
    add_we       = 1'b0;
    start_we     = 1'b0;
    start_val    = item_q.now_ms;
    retime_we    = 1'b0;
    run_we       = 1'b0;
    ins_we       = 1'b0;
    del_we       = 1'b0;
    load_item    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          load_item = 1'b1;
          pos_d     = '0;
          status_d  = pptb_pkg::STATUS_OK;
          state_d   = S_ACK;
          case (in_data_i.func)
            pptb_pkg::FUNC_TICK: begin
              state_d = S_TICK;
            end
            pptb_pkg::FUNC_ADD: begin
              if (!in_range) begin
                status_d = pptb_pkg::STATUS_ABSENT;
              end else if (in_present) begin
                status_d = pptb_pkg::STATUS_PRESENT;
              end else begin
                add_we  = 1'b1;
                state_d = S_INS_SCAN;
              end
            end
            pptb_pkg::FUNC_REMOVE: begin
              if (!in_present) begin
                status_d = pptb_pkg::STATUS_ABSENT;
              end else begin
                state_d = S_DEL_SCAN;
              end
            end
            pptb_pkg::FUNC_RETIME: begin
              if (!in_present) begin
                status_d = pptb_pkg::STATUS_ABSENT;
              end else begin
                retime_we = 1'b1;
              end
            end
            pptb_pkg::FUNC_RUN: begin
              if (!in_present) begin
                status_d = pptb_pkg::STATUS_ABSENT;
              end else begin
                run_we = 1'b1;
              end
            end
            default: begin
              status_d = pptb_pkg::STATUS_OK;
            end
          endcase
        end
      end

      S_TICK: begin
        if (pos_in_list) begin
          // One listed slot per cycle; a firing slot waits for the output register.
          if (first_q || (running_q[cur] && reached)) begin
            if (out_free) begin
              start_we        = 1'b1;
              start_val       = first_q ? item_q.now_ms : advanced;
              out_vld_d       = 1'b1;
              out_d.kind       = pptb_pkg::KIND_FIRE;
              out_d.fired_slot = 4'(cur);
              out_d.main_due   = 1'b0;
              out_d.status     = pptb_pkg::STATUS_OK;
              out_d.last       = 1'b0;
              pos_d           = pos_q + 1'b1;
            end
          end else begin
            // A paused slot follows the current time.
            start_we  = !running_q[cur];
            start_val = item_q.now_ms;
            pos_d     = pos_q + 1'b1;
          end
        end else if (out_free) begin
          // Finish beat with the main period result.
          out_vld_d        = 1'b1;
          out_d.kind       = pptb_pkg::KIND_TICK;
          out_d.fired_slot = '0;
          out_d.status     = pptb_pkg::STATUS_OK;
          out_d.last       = 1'b1;
          if (first_q) begin
            out_d.main_due = 1'b1;
            main_start_d   = item_q.now_ms;
            first_d        = 1'b0;
          end else begin
            out_d.main_due = (item_q.period_ms != pptb_pkg::NO_MAIN_PERIOD) && reached;
            if (out_d.main_due) begin
              main_start_d = advanced;
            end
          end
          state_d = S_IDLE;
        end
      end

      S_INS_SCAN: begin
        if (pos_in_list && !ins_before) begin
          pos_d = pos_q + 1'b1;
        end else begin
          state_d = S_INS_SHIFT;
        end
      end

      S_INS_SHIFT: begin
        ins_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_ACK;
      end

      S_DEL_SCAN: begin
        if (cur == item_idx) begin
          state_d = S_DEL_SHIFT;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end

      S_DEL_SHIFT: begin
        del_we  = 1'b1;
        cnt_d   = cnt_q - 1'b1;
        state_d = S_ACK;
      end

      S_ACK: begin
        if (out_free) begin
          out_vld_d        = 1'b1;
          out_d.kind       = pptb_pkg::KIND_ACK;
          out_d.fired_slot = '0;
          out_d.main_due   = 1'b0;
          out_d.status     = status_q;
          out_d.last       = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      cnt_q        <= '0;
      first_q      <= 1'b1;
      main_start_q <= '0;
      status_q     <= pptb_pkg::STATUS_OK;
      out_vld_q    <= 1'b0;
      present_q    <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      cnt_q        <= cnt_d;
      first_q      <= first_d;
      main_start_q <= main_start_d;
      status_q     <= status_d;
      out_vld_q    <= out_vld_d;
      if (add_we) begin
        present_q[in_idx] <= 1'b1;
      end
      if (del_we) begin
        present_q[item_idx] <= 1'b0;
      end
    end
  end

  // Payload registers and slot storage.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_item) begin
      item_q <= in_data_i;
    end
    if (add_we) begin
      period_q[in_idx]  <= in_data_i.period_ms;
      prio_q[in_idx]    <= in_data_i.prio;
      start_q[in_idx]   <= '0;
      running_q[in_idx] <= 1'b1;
    end
    if (retime_we) begin
      period_q[in_idx] <= in_data_i.period_ms;
      start_q[in_idx]  <= in_data_i.now_ms;
    end
    if (run_we) begin
      running_q[in_idx] <= in_data_i.run;
    end
    if (start_we) begin
      start_q[cur] <= start_val;
    end
    // List shifts: open a gap at the scan position, or close it.
    for (int i = 0; i < NS; i++) begin
      if (ins_we) begin
        if (CW'(i) == pos_q) begin
          order_q[i] <= item_idx;
        end else if (CW'(i) > pos_q) begin
          order_q[i] <= order_q[(i > 0) ? i - 1 : 0];
        end
      end
      if (del_we && (CW'(i) >= pos_q) && (i < NS - 1)) begin
        order_q[i] <= order_q[(i < NS - 1) ? i + 1 : i];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Between items the list length matches the number of present slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(present_q) == int'(cnt_q)))
    else $error("list count differs from present slot count");

  // An accepted beat holds off the input channel in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input taken again right after an accept");

  // The first tick is armed only by reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |=> !first_q)
    else $error("first tick flag set again");

  // Fire beats never close an item; finish and acknowledge beats always do.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.kind == pptb_pkg::KIND_FIRE) != out_q.last))
    else $error("last marker does not match the result kind");

endmodule
